>>> hw/rtl/accel_offset_matrix_correct_macros.svh
// assertion helpers shared by the calibration block
`ifndef ACCEL_OFFSET_MATRIX_CORRECT_MACROS_SVH
`define ACCEL_OFFSET_MATRIX_CORRECT_MACROS_SVH

// same-cycle implication, off while reset is high
`define AOMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aomc assertion failed");

// next-cycle implication, off while reset is high
`define AOMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aomc assertion failed");

`endif

>>> hw/rtl/aomc_pkg.sv
package aomc_pkg;

   // default build values
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int RESULT_WIDTH_DEF   = 24;

   // fixed field widths
   localparam int RAW_W      = 16;
   localparam int SCALED_W   = 21;   // raw count times 25
   localparam int OFFSET_W   = 24;
   localparam int D_W        = 26;   // scaled minus offset, exact
   localparam int COEF_W     = 16;
   localparam int GAIN_W     = 3 * COEF_W;
   localparam int PROD_W     = D_W + COEF_W;
   localparam int REQ_DATA_W = 3 * RAW_W;
   localparam int CSR_DATA_W = GAIN_W;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ROW_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ROW_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ROW_Z = 3'd5;

   // load strobes for the row datapath stages
   typedef struct packed {
      logic load_mul;
      logic load_sum;
      logic load_out;
   } stage_ctl_type;

endpackage

>>> hw/rtl/accel_offset_matrix_correct.sv
// channel   direction  handshake             payload
// req       in         req_tvalid/tready     raw_x, raw_y, raw_z
// rsp       out        rsp_tvalid/tready     accel_x, accel_y, accel_z
// csr       in         csr_we (no wait)      csr_index, csr_wdata
//
// five register stages: scale, offset, multiply, sum, round/clamp into the output register
// one request per cycle while req_tready is high; rsp_tvalid marks a full output register
// synchronous reset empties the pipeline and loads zero offsets and an identity matrix
// each stage moves when it is empty or the stage after it moves, so bubbles close up
// and requests keep entering while a result waits on rsp_tready, until every stage is full
`include "accel_offset_matrix_correct_macros.svh"

module accel_offset_matrix_correct #(
   parameter int COEF_FRAC_BITS = aomc_pkg::COEF_FRAC_BITS_DEF,
   parameter int RESULT_WIDTH   = aomc_pkg::RESULT_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
   input  logic [aomc_pkg::REQ_DATA_W-1:0]           req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // accel_x, accel_y, accel_z, RESULT_WIDTH bits each from bit 0, zero fill to bytes
   output logic [((3*RESULT_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                      csr_we,
   input  logic [aomc_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [aomc_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import aomc_pkg::*;

   localparam int RSP_DATA_W = ((3*RESULT_WIDTH+7)/8)*8;
   localparam int NSTAGE     = 5;

   localparam logic [GAIN_W-1:0] GAIN_X_RST = GAIN_W'(1) << COEF_FRAC_BITS;
   localparam logic [GAIN_W-1:0] GAIN_Y_RST = GAIN_W'(1) << (COEF_FRAC_BITS + COEF_W);
   localparam logic [GAIN_W-1:0] GAIN_Z_RST = GAIN_W'(1) << (COEF_FRAC_BITS + 2*COEF_W);

   // configuration
   logic signed [OFFSET_W-1:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic        [GAIN_W-1:0]   gain_row_x_ff, gain_row_y_ff, gain_row_z_ff;

   // pipeline control
   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic [NSTAGE-1:0] rdy;
   logic [NSTAGE-1:0] load;
   stage_ctl_type     row_ctl;

   // front stages
   logic signed [RAW_W-1:0]    raw_x, raw_y, raw_z;
   logic signed [SCALED_W-1:0] raw_x_ext, raw_y_ext, raw_z_ext;
   logic signed [SCALED_W-1:0] scaled_x_ff, scaled_y_ff, scaled_z_ff;
   logic signed [SCALED_W-1:0] scaled_x_in, scaled_y_in, scaled_z_in;
   logic signed [D_W-1:0]      d_x_ff, d_y_ff, d_z_ff;
   logic signed [D_W-1:0]      d_x_in, d_y_in, d_z_in;

   logic signed [RESULT_WIDTH-1:0] accel_x, accel_y, accel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         offset_z_ff   <= '0;
         gain_row_x_ff <= GAIN_X_RST;
         gain_row_y_ff <= GAIN_Y_RST;
         gain_row_z_ff <= GAIN_Z_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OFFSET_X:   offset_x_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_Y:   offset_y_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_Z:   offset_z_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_GAIN_ROW_X: gain_row_x_ff <= csr_wdata;
            CSR_GAIN_ROW_Y: gain_row_y_ff <= csr_wdata;
            CSR_GAIN_ROW_Z: gain_row_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ready ripples back from the output register
   always_comb begin
      rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_tready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      load[0]   = rdy[0] && req_tvalid;
      for (int i = 1; i < NSTAGE; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
         load[i]   = rdy[i] && vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign row_ctl.load_mul = load[2];
   assign row_ctl.load_sum = load[3];
   assign row_ctl.load_out = load[4];

   // scale by 25 as 16 + 8 + 1
   assign raw_x = $signed(req_tdata[RAW_W-1:0]);
   assign raw_y = $signed(req_tdata[2*RAW_W-1:RAW_W]);
   assign raw_z = $signed(req_tdata[3*RAW_W-1:2*RAW_W]);

   assign raw_x_ext = SCALED_W'(raw_x);
   assign raw_y_ext = SCALED_W'(raw_y);
   assign raw_z_ext = SCALED_W'(raw_z);

   assign scaled_x_in = (raw_x_ext <<< 4) + (raw_x_ext <<< 3) + raw_x_ext;
   assign scaled_y_in = (raw_y_ext <<< 4) + (raw_y_ext <<< 3) + raw_y_ext;
   assign scaled_z_in = (raw_z_ext <<< 4) + (raw_z_ext <<< 3) + raw_z_ext;

   assign d_x_in = D_W'(scaled_x_ff) - D_W'(offset_x_ff);
   assign d_y_in = D_W'(scaled_y_ff) - D_W'(offset_y_ff);
   assign d_z_in = D_W'(scaled_z_ff) - D_W'(offset_z_ff);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         scaled_x_ff <= scaled_x_in;
         scaled_y_ff <= scaled_y_in;
         scaled_z_ff <= scaled_z_in;
      end
      if (load[1]) begin
         d_x_ff <= d_x_in;
         d_y_ff <= d_y_in;
         d_z_ff <= d_z_in;
      end
   end

   aomc_row #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .RESULT_WIDTH   (RESULT_WIDTH)
   ) u_row_x (
      .clock (clock),
      .ctl   (row_ctl),
      .d_x   (d_x_ff),
      .d_y   (d_y_ff),
      .d_z   (d_z_ff),
      .gain  (gain_row_x_ff),
      .accel (accel_x)
   );

   aomc_row #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .RESULT_WIDTH   (RESULT_WIDTH)
   ) u_row_y (
      .clock (clock),
      .ctl   (row_ctl),
      .d_x   (d_x_ff),
      .d_y   (d_y_ff),
      .d_z   (d_z_ff),
      .gain  (gain_row_y_ff),
      .accel (accel_y)
   );

   aomc_row #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .RESULT_WIDTH   (RESULT_WIDTH)
   ) u_row_z (
      .clock (clock),
      .ctl   (row_ctl),
      .d_x   (d_x_ff),
      .d_y   (d_y_ff),
      .d_z   (d_z_ff),
      .gain  (gain_row_z_ff),
      .accel (accel_z)
   );

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NSTAGE-1];
   assign rsp_tdata  = RSP_DATA_W'({accel_z, accel_y, accel_x});

   // an accepted request always lands in the first stage
   `AOMC_ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, vld_ff[0])
   // a stage held by a stalled successor keeps its item
   `AOMC_ASSERT_NEXT(a_sum_holds, clock, reset, vld_ff[3] && !rdy[4], vld_ff[3])
   // a full pipeline with a stalled output takes no request
   `AOMC_ASSERT_NOW(a_full_blocks, clock, reset,
                    (vld_ff == {NSTAGE{1'b1}}) && !rsp_tready, !req_tready)
   // a result taken with nothing behind it leaves the output empty
   `AOMC_ASSERT_NEXT(a_out_drains, clock, reset,
                     rsp_tvalid && rsp_tready && !vld_ff[3], !rsp_tvalid)

endmodule

>>> hw/rtl/aomc_row.sv
module aomc_row #(
   parameter int COEF_FRAC_BITS = aomc_pkg::COEF_FRAC_BITS_DEF,
   parameter int RESULT_WIDTH   = aomc_pkg::RESULT_WIDTH_DEF
) (
   input  logic                                clock,
   input  aomc_pkg::stage_ctl_type             ctl,
   input  logic signed [aomc_pkg::D_W-1:0]     d_x,
   input  logic signed [aomc_pkg::D_W-1:0]     d_y,
   input  logic signed [aomc_pkg::D_W-1:0]     d_z,
   input  logic        [aomc_pkg::GAIN_W-1:0]  gain,
   output logic signed [RESULT_WIDTH-1:0]      accel
);
   import aomc_pkg::*;

   // wide enough for three products plus rounding, and to leave a sign bit above the result
   localparam int ACC_MIN_W = PROD_W + 3;
   localparam int ACC_W = (ACC_MIN_W > RESULT_WIDTH + COEF_FRAC_BITS + 1) ?
                          ACC_MIN_W : RESULT_WIDTH + COEF_FRAC_BITS + 1;
   localparam int SHR_W = ACC_W - COEF_FRAC_BITS;

   localparam logic signed [ACC_W-1:0] RND =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [SHR_W-1:0] MAXV =
      {{(SHR_W-RESULT_WIDTH+1){1'b0}}, {(RESULT_WIDTH-1){1'b1}}};
   localparam logic signed [SHR_W-1:0] MINV = ~MAXV;

   logic signed [COEF_W-1:0] coef_x, coef_y, coef_z;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_shifted;
   logic signed [SHR_W-1:0]  shr;
   logic signed [RESULT_WIDTH-1:0] accel_ff, accel_in;

   assign coef_x = $signed(gain[COEF_W-1:0]);
   assign coef_y = $signed(gain[2*COEF_W-1:COEF_W]);
   assign coef_z = $signed(gain[3*COEF_W-1:2*COEF_W]);

   // stage: one product per axis
   always_comb begin
      prod_x_in = PROD_W'(d_x) * PROD_W'(coef_x);
      prod_y_in = PROD_W'(d_y) * PROD_W'(coef_y);
      prod_z_in = PROD_W'(d_z) * PROD_W'(coef_z);
   end

   // stage: sum with the half-lsb rounding term folded in
   assign acc_in = ACC_W'(prod_x_ff) + ACC_W'(prod_y_ff) + ACC_W'(prod_z_ff) + RND;

   // stage: floor shift then clamp
   assign acc_shifted = acc_ff >>> COEF_FRAC_BITS;
   assign shr         = acc_shifted[SHR_W-1:0];

   always_comb begin
      priority if (shr > MAXV) begin
         accel_in = MAXV[RESULT_WIDTH-1:0];
      end else if (shr < MINV) begin
         accel_in = MINV[RESULT_WIDTH-1:0];
      end else begin
         accel_in = shr[RESULT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
      if (ctl.load_sum) begin
         acc_ff <= acc_in;
      end
      if (ctl.load_out) begin
         accel_ff <= accel_in;
      end
   end

   assign accel = accel_ff;

endmodule
